FILE: hw/rtl/skf_pkg.sv
`timescale 1ns / 1ps

package skf_pkg;

    // Defaults for the top-level parameters
    localparam int CHANNELS_DEF  = 6;
    localparam int FRAC_BITS_DEF = 16;

    // Channels below this index use the accelerometer noise set
    localparam int ACC_CHANNELS = 3;

    // Fixed field and register widths
    localparam int SAMPLE_W  = 16;
    localparam int CHAN_W    = 3;
    localparam int REG_W     = 24;
    localparam int COV_W     = 25;
    localparam int PP_W      = COV_W + 1;   // P + Q
    localparam int DEN_W     = COV_W + 2;   // P + Q + R
    localparam int CFG_IDX_W = 3;

    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACC_Q   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACC_R   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACC_P0  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_Q  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_R  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_P0 = 3'd5;

    // Reset values, unsigned Q8.16
    localparam logic [REG_W-1:0] RST_ACC_Q   = 24'd4096;
    localparam logic [REG_W-1:0] RST_ACC_R   = 24'd65536;
    localparam logic [REG_W-1:0] RST_ACC_P0  = 24'd14418;
    localparam logic [REG_W-1:0] RST_GYRO_Q  = 24'd196608;
    localparam logic [REG_W-1:0] RST_GYRO_R  = 24'd8192;
    localparam logic [REG_W-1:0] RST_GYRO_P0 = 24'd27525;

    typedef enum logic [1:0] {
        KIND_FILTER,
        KIND_REINIT,
        KIND_SKIP
    } t_kind;

    typedef struct packed {
        t_kind                       kind;
        logic                        is_acc;
        logic [CHAN_W-1:0]           channel;
        logic signed [SAMPLE_W-1:0]  sample;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SETUP,
        ST_DIV,
        ST_KPREP,
        ST_MUL,
        ST_UPDATE,
        ST_DONE
    } t_bstate;

endpackage

FILE: hw/rtl/skf_fifo.sv
`timescale 1ns / 1ps

module skf_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  skf_pkg::t_cmd    i_cmd,
    input  logic             i_pop,
    output skf_pkg::t_cmd    o_cmd,
    output skf_pkg::t_q_status o_status
);

    localparam int DEPTH = skf_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    skf_pkg::t_cmd     r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_count;

    logic w_push;
    logic w_pop;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign w_push = i_push && !o_status.full;
    assign w_pop  = i_pop && !o_status.empty;
    assign o_cmd  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

FILE: hw/rtl/skf_front.sv
`timescale 1ns / 1ps

module skf_front #(
    parameter int CHANNELS = skf_pkg::CHANNELS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_mode,
    input  logic [skf_pkg::CHAN_W-1:0]           i_channel,
    input  logic signed [skf_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic                                 i_pop,
    output skf_pkg::t_cmd                        o_cmd,
    output skf_pkg::t_q_status                   o_status
);

    skf_pkg::t_cmd w_cmd;
    logic          w_push;

    // Classify: reinit wins over channel checks; out-of-range channels become no-ops
    always_comb begin
        w_cmd.channel = i_channel;
        w_cmd.sample  = i_sample;
        w_cmd.is_acc  = (32'(i_channel) < skf_pkg::ACC_CHANNELS);
        priority if (i_mode) begin
            w_cmd.kind = skf_pkg::KIND_REINIT;
        end else if (32'(i_channel) >= CHANNELS) begin
            w_cmd.kind = skf_pkg::KIND_SKIP;
        end else begin
            w_cmd.kind = skf_pkg::KIND_FILTER;
        end
    end

    assign o_in_stall = o_status.full;
    assign w_push     = i_in_valid && !o_status.full;

    skf_fifo u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_cmd),
        .i_pop    (i_pop),
        .o_cmd    (o_cmd),
        .o_status (o_status)
    );

endmodule

FILE: hw/rtl/skf_back.sv
`timescale 1ns / 1ps

module skf_back #(
    parameter int CHANNELS      = skf_pkg::CHANNELS_DEF,
    parameter int FRACTION_BITS = skf_pkg::FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [skf_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [skf_pkg::REG_W-1:0]             i_cfg_wdata,
    input  skf_pkg::t_cmd                         i_q_cmd,
    input  skf_pkg::t_q_status                    i_q_status,
    output logic                                  o_pop,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [skf_pkg::SAMPLE_W-1:0]   o_filtered
);

    localparam int F      = FRACTION_BITS;
    localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int X_W    = skf_pkg::SAMPLE_W + F;      // signed Q16.F estimate
    localparam int DIFF_W = X_W + 1;
    localparam int KSH_W  = F + 1;
    localparam int ACC1_W = X_W + KSH_W;
    localparam int ACC2_W = skf_pkg::PP_W + KSH_W;
    localparam int CNT_W  = $clog2(F + 1);
    localparam int PP_W   = skf_pkg::PP_W;
    localparam int DEN_W  = skf_pkg::DEN_W;
    localparam int COV_W  = skf_pkg::COV_W;
    localparam int REG_W  = skf_pkg::REG_W;
    localparam int S_W    = skf_pkg::SAMPLE_W;

    localparam logic [KSH_W-1:0] ONE_FX = {1'b1, {F{1'b0}}};

    // Configuration registers
    logic [REG_W-1:0] r_acc_q, r_acc_r, r_acc_p0;
    logic [REG_W-1:0] r_gyro_q, r_gyro_r, r_gyro_p0;

    // Per-channel filter state
    logic signed [X_W-1:0] r_est [CHANNELS];
    logic [COV_W-1:0]      r_cov [CHANNELS];

    skf_pkg::t_bstate r_state, n_state;

    // Working registers for the item in flight
    logic [IDX_W-1:0]      r_ch;
    logic signed [S_W-1:0] r_sample;
    logic                  r_is_acc;
    logic [PP_W-1:0]       r_pp;
    logic [REG_W-1:0]      r_rmeas;
    logic [DEN_W-1:0]      r_den;
    logic [DEN_W-1:0]      r_rem;
    logic [F-1:0]          r_k;
    logic                  r_neg;
    logic [X_W-1:0]        r_mag;
    logic signed [X_W-1:0] r_x;
    logic [KSH_W-1:0]      r_kshift;
    logic [KSH_W-1:0]      r_cshift;
    logic [ACC1_W-1:0]     r_acc1;
    logic [ACC2_W-1:0]     r_acc2;
    logic [COV_W-1:0]      r_pnew;
    logic [CNT_W-1:0]      r_cnt;

    logic                  r_out_valid;
    logic signed [S_W-1:0] r_filtered;

    logic                  w_out_free;
    logic                  w_out_load;
    logic signed [S_W-1:0] w_out_val;
    logic                  w_reinit;
    logic                  w_commit;
    logic [REG_W-1:0]      w_q;
    logic [REG_W-1:0]      w_r;

    logic signed [DIFF_W-1:0] w_s_fx;
    logic signed [DIFF_W-1:0] w_diff;
    logic [DIFF_W-1:0]        w_mag_full;
    logic [DEN_W:0]           w_rem2;
    logic                     w_ge;
    logic [DEN_W:0]           w_sub;
    logic [X_W-1:0]           w_delta;
    logic signed [S_W-1:0]    w_floor;
    logic                     w_round_up;
    logic signed [S_W-1:0]    w_filt;

    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_q = r_is_acc ? r_acc_q : r_gyro_q;
    assign w_r = r_is_acc ? r_acc_r : r_gyro_r;

    // sample * 2^F - X; |diff| never exceeds 65535 * 2^F
    assign w_s_fx     = {r_sample[S_W-1], r_sample, {F{1'b0}}};
    assign w_diff     = w_s_fx - {r_x[X_W-1], r_x};
    assign w_mag_full = w_diff[DIFF_W-1] ? DIFF_W'(-w_diff) : DIFF_W'(w_diff);

    // restoring divider step
    assign w_rem2 = {r_rem, 1'b0};
    assign w_ge   = (w_rem2 >= {1'b0, r_den});
    assign w_sub  = w_rem2 - {1'b0, r_den};

    assign w_delta = r_acc1[F +: X_W];

    // truncate toward zero: floor, plus one for negative values with a fraction
    assign w_floor    = r_x[X_W-1 -: S_W];
    assign w_round_up = r_x[X_W-1] && (r_x[F-1:0] != '0);
    assign w_filt     = w_floor + S_W'(w_round_up);

    // Sequencer
    always_comb begin
        n_state    = r_state;
        o_pop      = 1'b0;
        w_out_load = 1'b0;
        w_out_val  = '0;
        w_commit   = 1'b0;
        unique case (r_state)
            skf_pkg::ST_IDLE: begin
                if (!i_q_status.empty) begin
                    unique case (i_q_cmd.kind)
                        skf_pkg::KIND_FILTER: begin
                            o_pop   = 1'b1;
                            n_state = skf_pkg::ST_PREP;
                        end
                        skf_pkg::KIND_REINIT, skf_pkg::KIND_SKIP: begin
                            if (w_out_free) begin
                                o_pop      = 1'b1;
                                w_out_load = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            skf_pkg::ST_PREP:  n_state = skf_pkg::ST_SETUP;
            skf_pkg::ST_SETUP: begin
                n_state = (r_rmeas == '0) ? skf_pkg::ST_KPREP : skf_pkg::ST_DIV;
            end
            skf_pkg::ST_DIV: begin
                if (r_cnt == '0) n_state = skf_pkg::ST_KPREP;
            end
            skf_pkg::ST_KPREP: n_state = skf_pkg::ST_MUL;
            skf_pkg::ST_MUL: begin
                if (r_cnt == '0) n_state = skf_pkg::ST_UPDATE;
            end
            skf_pkg::ST_UPDATE: n_state = skf_pkg::ST_DONE;
            skf_pkg::ST_DONE: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    w_out_val  = w_filt;
                    w_commit   = 1'b1;
                    n_state    = skf_pkg::ST_IDLE;
                end
            end
            default: n_state = skf_pkg::ST_IDLE;
        endcase
    end

    assign w_reinit = o_pop && (i_q_cmd.kind == skf_pkg::KIND_REINIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= skf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers; indexes past the list are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_q   <= skf_pkg::RST_ACC_Q;
            r_acc_r   <= skf_pkg::RST_ACC_R;
            r_acc_p0  <= skf_pkg::RST_ACC_P0;
            r_gyro_q  <= skf_pkg::RST_GYRO_Q;
            r_gyro_r  <= skf_pkg::RST_GYRO_R;
            r_gyro_p0 <= skf_pkg::RST_GYRO_P0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                skf_pkg::CFG_ACC_Q:   r_acc_q   <= i_cfg_wdata;
                skf_pkg::CFG_ACC_R:   r_acc_r   <= i_cfg_wdata;
                skf_pkg::CFG_ACC_P0:  r_acc_p0  <= i_cfg_wdata;
                skf_pkg::CFG_GYRO_Q:  r_gyro_q  <= i_cfg_wdata;
                skf_pkg::CFG_GYRO_R:  r_gyro_r  <= i_cfg_wdata;
                skf_pkg::CFG_GYRO_P0: r_gyro_p0 <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Channel state: reset and reinit load every channel at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_est[c] <= '0;
                r_cov[c] <= (c < skf_pkg::ACC_CHANNELS) ? COV_W'(skf_pkg::RST_ACC_P0)
                                                        : COV_W'(skf_pkg::RST_GYRO_P0);
            end
        end else if (w_reinit) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_est[c] <= '0;
                r_cov[c] <= (c < skf_pkg::ACC_CHANNELS) ? COV_W'(r_acc_p0)
                                                        : COV_W'(r_gyro_p0);
            end
        end else if (w_commit) begin
            r_est[r_ch] <= r_x;
            r_cov[r_ch] <= r_pnew;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            skf_pkg::ST_IDLE: begin
                if (o_pop) begin
                    r_ch     <= IDX_W'(i_q_cmd.channel);
                    r_sample <= i_q_cmd.sample;
                    r_is_acc <= i_q_cmd.is_acc;
                end
            end
            skf_pkg::ST_PREP: begin
                r_pp    <= PP_W'(r_cov[r_ch]) + PP_W'(w_q);
                r_rmeas <= w_r;
                r_x     <= r_est[r_ch];
            end
            skf_pkg::ST_SETUP: begin
                r_den <= DEN_W'(r_pp) + DEN_W'(r_rmeas);
                r_rem <= DEN_W'(r_pp);
                r_neg <= w_diff[DIFF_W-1];
                r_mag <= w_mag_full[X_W-1:0];
                r_cnt <= CNT_W'(F - 1);
                // R of zero: gain saturates, or is zero when P + Q is zero too
                if (r_rmeas == '0) begin
                    r_k <= (r_pp == '0) ? '0 : '1;
                end else begin
                    r_k <= '0;
                end
            end
            skf_pkg::ST_DIV: begin
                r_rem <= w_ge ? w_sub[DEN_W-1:0] : w_rem2[DEN_W-1:0];
                r_k   <= {r_k[F-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
            end
            skf_pkg::ST_KPREP: begin
                r_kshift <= {1'b0, r_k};
                r_cshift <= ONE_FX - {1'b0, r_k};
                r_acc1   <= '0;
                r_acc2   <= '0;
                r_cnt    <= CNT_W'(F);
            end
            skf_pkg::ST_MUL: begin
                // MSB-first shift-add: mag * K and (1 - K) * Pp side by side
                r_acc1   <= {r_acc1[ACC1_W-2:0], 1'b0}
                          + (r_kshift[F] ? ACC1_W'(r_mag) : '0);
                r_acc2   <= {r_acc2[ACC2_W-2:0], 1'b0}
                          + (r_cshift[F] ? ACC2_W'(r_pp) : '0);
                r_kshift <= {r_kshift[F-1:0], 1'b0};
                r_cshift <= {r_cshift[F-1:0], 1'b0};
                r_cnt    <= r_cnt - 1'b1;
            end
            skf_pkg::ST_UPDATE: begin
                r_x    <= r_neg ? (r_x - $signed(w_delta)) : (r_x + $signed(w_delta));
                r_pnew <= r_acc2[F +: COV_W];
            end
            skf_pkg::ST_DONE: ;
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_filtered <= w_out_val;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_filtered  = r_filtered;

endmodule

FILE: hw/rtl/scalar_kalman_six_channel_unit.sv
`timescale 1ns / 1ps

// Six scalar Kalman filters (channels 0-2 accelerometer, 3-5 gyro) sharing one
// serial datapath. Each input item is either a sample for one channel (mode 0)
// or a reinit of all channels (mode 1); every item yields exactly one result.
// Items first land in a two-entry queue, so the input side keeps accepting,
// until the queue is full, while a result waits to be taken. In the back
// end a filter item passes prep and setup states; the gain P/(P+R) comes
// from a one-bit-per-cycle restoring divider (skipped when R is zero), then
// K*(sample-X) and (1-K)*P come from a pair of shift-add multipliers, and
// update and done states follow. Reinit and out-of-range items skip the
// datapath and return 0. Results leave through an output register. Noise and
// initial-error registers are Q8.16; write them only while the block is idle.

module scalar_kalman_six_channel_unit #(
    parameter int CHANNELS      = skf_pkg::CHANNELS_DEF,
    parameter int FRACTION_BITS = skf_pkg::FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,

    // configuration write port
    input  logic                                  i_cfg_we,
    input  logic [skf_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [skf_pkg::REG_W-1:0]             i_cfg_wdata,

    // input item channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_mode,
    input  logic [skf_pkg::CHAN_W-1:0]            i_channel,
    input  logic signed [skf_pkg::SAMPLE_W-1:0]   i_sample,

    // result item channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [skf_pkg::SAMPLE_W-1:0]   o_filtered
);

    skf_pkg::t_cmd      w_cmd;
    skf_pkg::t_q_status w_status;
    logic               w_pop;

    // front end: classify and queue
    skf_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_mode     (i_mode),
        .i_channel  (i_channel),
        .i_sample   (i_sample),
        .i_pop      (w_pop),
        .o_cmd      (w_cmd),
        .o_status   (w_status)
    );

    // back end: filter state, serial arithmetic, output register
    skf_back #(
        .CHANNELS      (CHANNELS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_cmd     (w_cmd),
        .i_q_status  (w_status),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_filtered  (o_filtered)
    );

endmodule
